FILE: src/rpd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the RLE pixel packet decoder.
// No dependencies; the top level, rpd_parse and rpd_ostage import this package.
package rpd_pkg;

   // Default palette depth
   localparam int unsigned PALETTE_DEPTH_DEF = 256;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_PALETTE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEMENT_BYTES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_COUNT   = 2'd2;

   // Item function codes
   localparam logic FUNC_STREAM  = 1'b0;
   localparam logic FUNC_PALETTE = 1'b1;

   // Packet header fields
   localparam logic [7:0] HDR_COUNT_MASK = 8'h7F;
   localparam int unsigned HDR_REPEAT_BIT = 7;

   // Reset values of the configuration registers
   localparam logic [2:0]  ELEMENT_BYTES_RST = 3'd4;
   localparam logic [31:0] PIXEL_COUNT_RST   = 32'd1;

   // One completed element on its way to the output
   typedef struct packed {
      logic [31:0] value;
      logic [7:0]  count;
      logic        done;
   } elem_type;

endpackage

FILE: src/rle_pixel_packet_decoder.sv
`timescale 1ns / 1ps
// Targa RLE pixel packet decoder, top level.
// Depends on rpd_pkg, rpd_parse, rpd_ostage and rpd_ram.
//
// Usage:
//  - req_ channel takes one item per cycle while req_ready is high. func 0
//    carries a byte of the compressed stream, func 1 writes palette_value
//    into entry palette_slot (mod palette depth); a palette write gives no result.
//  - rsp_ channel gives one result per completed element: pixel value, repeat
//    count and an end-of-image flag. Header bytes and non-final element bytes
//    give no result.
//  - csr_ port writes use_palette, element_bytes and pixel_count; a pixel_count
//    write starts a new image. Write only while the block is idle.
//  - Throughput: one item per cycle, sustained, as long as rsp_ready is high.
//  - Result path: the element is held in the read stage while the synchronous
//    palette RAM read completes, then moves into the result register.
//  - Reset (synchronous) restores register defaults and expects a header; the
//    palette RAM is not cleared and must be written before it is used.
//  - When the receiver stalls, the result register holds and the read stage
//    still takes one more item; after that req_ready drops until rsp_ready.
module rle_pixel_packet_decoder #(
   parameter int unsigned PALETTE_DEPTH = rpd_pkg::PALETTE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [7:0]                    req_data_byte,
   input  logic [7:0]                    req_palette_slot,
   input  logic [31:0]                   req_palette_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [31:0]                   rsp_pixel_value,
   output logic [7:0]                    rsp_repeat_count,
   output logic                          rsp_image_done,
   input  logic                          csr_wr_en,
   input  logic [rpd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wr_data
);
   import rpd_pkg::*;

   localparam int unsigned IDX_W = $clog2(PALETTE_DEPTH);

   logic             accept;
   logic             step;
   logic             load;
   logic             can_load;
   logic             elem_fire;
   elem_type         elem;
   logic [IDX_W-1:0] elem_index;
   logic [IDX_W-1:0] slot_index;
   logic             use_palette;
   logic [31:0]      ram_rdata;

   // Item handshake
   assign req_ready = can_load;
   assign accept    = req_valid && req_ready;
   assign step      = accept && (req_func == FUNC_STREAM);
   assign load      = step && elem_fire;

   rpd_parse #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_parse (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .step         (step),
      .data_byte    (req_data_byte),
      .palette_slot (req_palette_slot),
      .elem_fire    (elem_fire),
      .elem         (elem),
      .elem_index   (elem_index),
      .slot_index   (slot_index),
      .use_palette  (use_palette)
   );

   // Palette store: written by palette items, read as an element completes when use_palette is set
   rpd_ram #(
      .WIDTH (32),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (accept && (req_func == FUNC_PALETTE)),
      .wr_addr (slot_index),
      .wr_data (req_palette_value),
      .rd_en   (load && use_palette),
      .rd_addr (elem_index),
      .rd_data (ram_rdata)
   );

   rpd_ostage u_ostage (
      .clock            (clock),
      .reset            (reset),
      .load             (load),
      .elem             (elem),
      .elem_pal         (use_palette),
      .ram_rdata        (ram_rdata),
      .can_load         (can_load),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_image_done   (rsp_image_done)
   );

endmodule

FILE: src/rpd_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rpd_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/rpd_parse.sv
`timescale 1ns / 1ps
// Byte parser: configuration registers, packet header decode, element assembly,
// pixel accounting and palette index reduction. Depends on rpd_pkg.
module rpd_parse #(
   parameter int unsigned PALETTE_DEPTH = rpd_pkg::PALETTE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [rpd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                      csr_wr_data,
   input  logic                             step,
   input  logic [7:0]                       data_byte,
   input  logic [7:0]                       palette_slot,
   output logic                             elem_fire,
   output rpd_pkg::elem_type                elem,
   output logic [$clog2(PALETTE_DEPTH)-1:0] elem_index,
   output logic [$clog2(PALETTE_DEPTH)-1:0] slot_index,
   output logic                             use_palette
);
   import rpd_pkg::*;

   localparam int unsigned IDX_W = $clog2(PALETTE_DEPTH);

   // Weight of each byte lane modulo the palette depth (256^lane mod depth)
   localparam int unsigned WGT0 = 1 % PALETTE_DEPTH;
   localparam int unsigned WGT1 = 256 % PALETTE_DEPTH;
   localparam int unsigned WGT2 = (WGT1 * 256) % PALETTE_DEPTH;
   localparam int unsigned WGT3 = (WGT2 * 256) % PALETTE_DEPTH;

   // Configuration registers
   logic        use_palette_ff;
   logic [2:0]  element_bytes_ff;
   logic [31:0] pixel_count_ff;

   // Stream state
   logic              expect_header_ff, expect_header_in;
   logic              repeat_packet_ff, repeat_packet_in;
   logic [7:0]        packet_left_ff, packet_left_in;
   logic [1:0]        byte_pos_ff, byte_pos_in;
   logic [31:0]       assembly_ff, assembly_in;
   logic [IDX_W-1:0]  index_ff, index_in;
   logic [31:0]       image_left_ff, image_left_in;

   logic [IDX_W-1:0]  lane_tbl [4][256];
   logic [IDX_W-1:0]  lane_term;
   logic [IDX_W-1:0]  index_base;
   logic [IDX_W:0]    index_sum;
   logic [IDX_W-1:0]  index_next;
   logic [31:0]       assembly_base;
   logic [31:0]       assembly_next;
   logic [2:0]        eff_bytes;
   logic              last_byte;
   logic [31:0]       eff_pixels;
   logic [7:0]        hdr_count;
   logic [7:0]        run_count;
   logic [31:0]       image_after;
   logic [7:0]        packet_after;
   logic              image_end;

   // Constant tables of (byte * lane weight) mod depth
   for (genvar g = 0; g < 256; g++) begin : g_lane
      assign lane_tbl[0][g] = IDX_W'((g * WGT0) % PALETTE_DEPTH);
      assign lane_tbl[1][g] = IDX_W'((g * WGT1) % PALETTE_DEPTH);
      assign lane_tbl[2][g] = IDX_W'((g * WGT2) % PALETTE_DEPTH);
      assign lane_tbl[3][g] = IDX_W'((g * WGT3) % PALETTE_DEPTH);
   end

   assign slot_index = lane_tbl[0][palette_slot];

   // Effective element size: 0 acts as 1, above 4 acts as 4
   always_comb begin
      case (element_bytes_ff) inside
         3'd0:         eff_bytes = 3'd1;
         [3'd1:3'd4]:  eff_bytes = element_bytes_ff;
         default:      eff_bytes = 3'd4;
      endcase
   end

   assign eff_pixels = (pixel_count_ff == 32'd0) ? 32'd1 : pixel_count_ff;

   // Byte lane assembly and running index modulo depth
   always_comb begin
      assembly_base = (byte_pos_ff == 2'd0) ? 32'd0 : assembly_ff;
      assembly_next = assembly_base | (32'(data_byte) << {byte_pos_ff, 3'b000});
      index_base    = (byte_pos_ff == 2'd0) ? '0 : index_ff;
      lane_term     = lane_tbl[byte_pos_ff][data_byte];
      index_sum     = {1'b0, index_base} + {1'b0, lane_term};
      if (index_sum >= (IDX_W + 1)'(PALETTE_DEPTH)) begin
         index_sum = index_sum - (IDX_W + 1)'(PALETTE_DEPTH);
      end
      index_next = index_sum[IDX_W-1:0];
      last_byte  = ({1'b0, byte_pos_ff} + 3'd1) >= eff_bytes;
   end

   // Header count clamp and pixel accounting
   always_comb begin
      hdr_count = (data_byte & HDR_COUNT_MASK) + 8'd1;
      if (image_left_ff < 32'(hdr_count)) begin
         hdr_count = image_left_ff[7:0];
      end
      run_count = repeat_packet_ff ? packet_left_ff : 8'd1;
      if (image_left_ff < 32'(run_count)) begin
         run_count = image_left_ff[7:0];
      end
      image_after  = image_left_ff - 32'(run_count);
      packet_after = repeat_packet_ff ? 8'd0 : packet_left_ff - 8'd1;
      image_end    = (image_after == 32'd0);
   end

   // Next stream state
   always_comb begin
      expect_header_in = expect_header_ff;
      repeat_packet_in = repeat_packet_ff;
      packet_left_in   = packet_left_ff;
      byte_pos_in      = byte_pos_ff;
      assembly_in      = assembly_ff;
      index_in         = index_ff;
      image_left_in    = image_left_ff;
      elem_fire        = 1'b0;
      if (step) begin
         if (expect_header_ff) begin
            packet_left_in   = hdr_count;
            repeat_packet_in = data_byte[HDR_REPEAT_BIT];
            expect_header_in = 1'b0;
            byte_pos_in      = 2'd0;
         end else if (!last_byte) begin
            assembly_in = assembly_next;
            index_in    = index_next;
            byte_pos_in = byte_pos_ff + 2'd1;
         end else begin
            elem_fire        = 1'b1;
            byte_pos_in      = 2'd0;
            packet_left_in   = packet_after;
            image_left_in    = image_after;
            expect_header_in = (packet_after == 8'd0);
            if (image_end) begin
               // image complete: rearm for the next one
               expect_header_in = 1'b1;
               repeat_packet_in = 1'b0;
               packet_left_in   = 8'd0;
               image_left_in    = eff_pixels;
            end
         end
      end
   end

   assign elem.value  = assembly_next;
   assign elem.count  = run_count;
   assign elem.done   = image_end;
   assign elem_index  = index_next;
   assign use_palette = use_palette_ff;

   // Registers; a pixel count write restarts the image
   always_ff @(posedge clock) begin
      assembly_ff <= assembly_in;
      index_ff    <= index_in;
      if (reset) begin
         use_palette_ff   <= 1'b0;
         element_bytes_ff <= ELEMENT_BYTES_RST;
         pixel_count_ff   <= PIXEL_COUNT_RST;
         expect_header_ff <= 1'b1;
         repeat_packet_ff <= 1'b0;
         packet_left_ff   <= 8'd0;
         byte_pos_ff      <= 2'd0;
         image_left_ff    <= PIXEL_COUNT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_USE_PALETTE: begin
               use_palette_ff <= csr_wr_data[0];
            end
            CSR_ELEMENT_BYTES: begin
               element_bytes_ff <= csr_wr_data[2:0];
            end
            CSR_PIXEL_COUNT: begin
               pixel_count_ff   <= csr_wr_data;
               expect_header_ff <= 1'b1;
               repeat_packet_ff <= 1'b0;
               packet_left_ff   <= 8'd0;
               byte_pos_ff      <= 2'd0;
               image_left_ff    <= (csr_wr_data == 32'd0) ? 32'd1 : csr_wr_data;
            end
            default: begin
            end
         endcase
      end else begin
         expect_header_ff <= expect_header_in;
         repeat_packet_ff <= repeat_packet_in;
         packet_left_ff   <= packet_left_in;
         byte_pos_ff      <= byte_pos_in;
         image_left_ff    <= image_left_in;
      end
   end

endmodule

FILE: src/rpd_ostage.sv
`timescale 1ns / 1ps
// Output pipeline: palette read stage followed by the result register.
// Depends on rpd_pkg.
module rpd_ostage (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  rpd_pkg::elem_type elem,
   input  logic              elem_pal,
   input  logic [31:0]       ram_rdata,
   output logic              can_load,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [31:0]       rsp_pixel_value,
   output logic [7:0]        rsp_repeat_count,
   output logic              rsp_image_done
);
   import rpd_pkg::*;

   logic     s1_valid_ff, s1_valid_in;
   elem_type s1_ff;
   logic     s1_pal_ff;
   logic     out_valid_ff, out_valid_in;
   elem_type out_ff;
   logic     advance;

   // The result register frees up when empty or taken
   assign advance  = !out_valid_ff || rsp_ready;
   assign can_load = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in  = load || (s1_valid_ff && !advance);
      out_valid_in = advance ? s1_valid_ff : out_valid_ff;
   end

   // Read stage holds the item while the palette RAM answers
   always_ff @(posedge clock) begin
      if (load) begin
         s1_ff     <= elem;
         s1_pal_ff <= elem_pal;
      end
      if (advance && s1_valid_ff) begin
         out_ff.value <= s1_pal_ff ? ram_rdata : s1_ff.value;
         out_ff.count <= s1_ff.count;
         out_ff.done  <= s1_ff.done;
      end
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pixel_value  = out_ff.value;
   assign rsp_repeat_count = out_ff.count;
   assign rsp_image_done   = out_ff.done;

endmodule

FILE: src/rpd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the RLE pixel packet decoder, bound to the top level.
// Depends on rle_pixel_packet_decoder.
module rpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_func,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_pixel_value,
   input logic [7:0]  rsp_repeat_count,
   input logic        rsp_image_done
);

   // Reset empties the result side
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Repeat count always within one packet
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_repeat_count != 8'd0) && (rsp_repeat_count <= 8'd128))
      else $error("repeat count out of range");

   // A fresh result follows an accepted stream item via read stage and result register
   a_cause: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |->
         $past(req_valid && req_ready && !req_func, 2))
      else $error("result without a stream item");

   // A stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_pixel_value) &&
         $stable(rsp_repeat_count) && $stable(rsp_image_done))
      else $error("stalled result changed");

endmodule

bind rle_pixel_packet_decoder rpd_checker u_rpd_checker (.*);
